// ===== hw/rtl/ccsx_pkg.sv =====
// shared types, constants and round functions for the chacha20 byte combiner
`timescale 1ns / 1ps

package ccsx_pkg;

  typedef logic [31:0]       word_t;
  typedef logic [3:0][31:0]  quad_t;
  typedef logic [15:0][31:0] block_t;
  typedef logic [7:0][31:0]  key_t;
  typedef logic [2:0][31:0]  nonce_t;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_PART_0 = 3'd0,
    CFG_KEY_PART_1 = 3'd1,
    CFG_KEY_PART_2 = 3'd2,
    CFG_KEY_PART_3 = 3'd3,
    CFG_NONCE_LOW  = 3'd4,
    CFG_NONCE_HIGH = 3'd5
  } cfg_reg_e;

  // "expand 32-byte k", word 0 in the low lane
  localparam quad_t SIGMA = {32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865};

  localparam int ROT_A = 16;
  localparam int ROT_B = 12;
  localparam int ROT_C = 8;
  localparam int ROT_D = 7;

  localparam int BLOCK_BYTES = 64;
  localparam int POS_W       = $clog2(BLOCK_BYTES);

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0]       data;
    logic [POS_W-1:0] pos;
    word_t            ctr;
    logic             new_blk;
  } item_t;

  typedef struct packed {
    logic  start;
    word_t ctr;
  } core_req_t;

  typedef struct packed {
    logic  busy;
    logic  done;
    word_t ctr;
  } core_stat_t;

  function automatic word_t rotl(word_t v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // lanes: 0 = a, 1 = b, 2 = c, 3 = d
  function automatic quad_t qr_mix(quad_t q);
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    a = q[0];
    b = q[1];
    c = q[2];
    d = q[3];
    a = a + b; d = rotl(d ^ a, ROT_A);
    c = c + d; b = rotl(b ^ c, ROT_B);
    a = a + b; d = rotl(d ^ a, ROT_C);
    c = c + d; b = rotl(b ^ c, ROT_D);
    return {d, c, b, a};
  endfunction

endpackage

// ===== hw/rtl/ccsx_front.sv =====
// front end: accepts bytes, tracks byte position and block counter
`timescale 1ns / 1ps

module ccsx_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [7:0]        data_byte,
  input  logic              message_start,
  input  logic              full,
  output logic              in_stall,
  output logic              push,
  output ccsx_pkg::item_t   item
);
  import ccsx_pkg::*;

  logic [POS_W-1:0] pos;
  word_t            ctr;
  logic [POS_W-1:0] pos_eff;
  word_t            ctr_eff;

  assign in_stall = full;
  assign push     = in_valid && !full;

  assign pos_eff = message_start ? '0 : pos;
  assign ctr_eff = message_start ? '0 : ctr;

  assign item = '{data: data_byte, pos: pos_eff, ctr: ctr_eff, new_blk: (pos_eff == '0)};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      ctr <= '0;
    end else if (push) begin
      pos <= pos_eff + POS_W'(1);
      ctr <= ctr_eff + ((pos_eff == '1) ? 32'd1 : 32'd0);
    end
  end

endmodule

// ===== hw/rtl/ccsx_queue.sv =====
// short item queue between front and back
`timescale 1ns / 1ps

module ccsx_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ccsx_pkg::item_t  wr_item,
  output logic             full,
  output logic             head_valid,
  output ccsx_pkg::item_t  head,
  input  logic             pop
);
  import ccsx_pkg::*;

  item_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

endmodule

// ===== hw/rtl/ccsx_core.sv =====
// keystream block generator, one round per cycle plus feed-forward
`timescale 1ns / 1ps

module ccsx_core #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ccsx_pkg::key_t       key,
  input  ccsx_pkg::nonce_t     nonce,
  input  ccsx_pkg::core_req_t  req,
  input  logic                 kill,
  output ccsx_pkg::core_stat_t stat,
  output ccsx_pkg::block_t     words
);
  import ccsx_pkg::*;

  localparam int NROUNDS = 2 * DOUBLE_ROUNDS;
  localparam int RW      = $clog2(NROUNDS + 1);
  localparam logic [RW-1:0] LAST = RW'(NROUNDS);

  block_t        w;
  block_t        w_rnd;
  block_t        init;
  logic          busy;
  logic [RW-1:0] rnd;
  word_t         ctr;

  logic [1:0] d1;
  logic [1:0] d2;
  logic [1:0] d3;
  logic [3:0] ib;
  logic [3:0] ic;
  logic [3:0] id;
  quad_t      q_in;
  quad_t      q_out;

  // even rounds work on columns, odd rounds on diagonals
  assign d1 = rnd[0] ? 2'd1 : 2'd0;
  assign d2 = rnd[0] ? 2'd2 : 2'd0;
  assign d3 = rnd[0] ? 2'd3 : 2'd0;

  always_comb begin
    w_rnd = w;
    ib    = '0;
    ic    = '0;
    id    = '0;
    q_in  = '0;
    q_out = '0;
    for (int i = 0; i < 4; i++) begin
      ib    = {2'b01, 2'(2'(i) + d1)};
      ic    = {2'b10, 2'(2'(i) + d2)};
      id    = {2'b11, 2'(2'(i) + d3)};
      q_in  = {w[id], w[ic], w[ib], w[i]};
      q_out = qr_mix(q_in);
      w_rnd[i]  = q_out[0];
      w_rnd[ib] = q_out[1];
      w_rnd[ic] = q_out[2];
      w_rnd[id] = q_out[3];
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      words[i] = w[i] + init[i];
    end
  end

  assign stat = '{busy: busy, done: busy && (rnd == LAST), ctr: ctr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd  <= '0;
    end else if (kill) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
      rnd  <= '0;
    end else if (busy) begin
      if (rnd == LAST) begin
        busy <= 1'b0;
      end else begin
        rnd <= rnd + RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !kill) begin
      init <= {nonce, req.ctr, key, SIGMA};
      w    <= {nonce, req.ctr, key, SIGMA};
      ctr  <= req.ctr;
    end else if (busy && rnd != LAST) begin
      w <= w_rnd;
    end
  end

endmodule

// ===== hw/rtl/ccsx_back.sv =====
// back end: block buffers, prefetch control and output register
`timescale 1ns / 1ps

module ccsx_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 flush,
  input  logic                 head_valid,
  input  ccsx_pkg::item_t      head,
  output logic                 pop,
  input  ccsx_pkg::core_stat_t stat,
  input  ccsx_pkg::block_t     core_words,
  output ccsx_pkg::core_req_t  req,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte
);
  import ccsx_pkg::*;

  block_t pf_words;
  word_t  pf_ctr;
  logic   pf_valid;
  block_t cur_words;
  word_t  cur_ctr;

  logic   pf_hit;
  logic   need;
  logic   blk_ok;
  logic   out_free;
  logic   consume;
  word_t  cur_word;
  logic [7:0] ks;

  assign pf_hit   = pf_valid && (pf_ctr == head.ctr);
  assign need     = head_valid && head.new_blk && !pf_hit;
  assign blk_ok   = !head.new_blk || pf_hit;
  assign out_free = !out_valid || !out_stall;
  assign pop      = head_valid && blk_ok && out_free;
  assign consume  = pop && head.new_blk;

  assign cur_word = cur_words[head.pos[POS_W-1:2]];
  assign ks       = head.new_blk ? pf_words[0][7:0]
                                 : 8'(cur_word >> {head.pos[1:0], 3'b000});

  // demand fetch wins over prefetch of the following block
  always_comb begin
    req.ctr   = need ? head.ctr : cur_ctr + 32'd1;
    req.start = 1'b0;
    if (!flush) begin
      if (need) begin
        req.start = !(stat.busy && stat.ctr == head.ctr);
      end else begin
        req.start = !pf_valid && !stat.busy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pf_valid  <= 1'b0;
      cur_ctr   <= '1;
      out_valid <= 1'b0;
    end else begin
      if (flush) begin
        pf_valid <= 1'b0;
      end else if (stat.done) begin
        pf_valid <= 1'b1;
      end else if (consume) begin
        pf_valid <= 1'b0;
      end
      if (consume) begin
        cur_ctr <= pf_ctr;
      end
      if (pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done && !flush) begin
      pf_words <= core_words;
      pf_ctr   <= stat.ctr;
    end
    if (consume) begin
      cur_words <= pf_words;
    end
    if (pop) begin
      out_byte <= head.data ^ ks;
    end
  end

endmodule

// ===== hw/rtl/chacha20_stream_xor.sv =====
// top level of the chacha20 byte combiner: config registers and unit wiring
// usage:
//   input channel (in_valid / in_stall) carries data_byte and message_start, one byte
//   per transaction; output channel (out_valid / out_stall) returns out_byte, the
//   input byte xor the next keystream byte, one transaction per input, in order.
//   message_start restarts the block counter and byte position at this byte.
//   key and nonce are written through cfg_we / cfg_index / cfg_data while idle;
//   a write drops any prefetched block so later blocks use the new values.
// path: an accepted byte goes into the queue, and once its block is ready into the
//   output register, which drives out_valid and out_byte.
// throughput: one byte per cycle sustained while out_stall is low. the block generator
//   does one round per cycle, so the next block is prefetched well within the 64
//   bytes of the current one.
//   a message start, the first byte after reset and the first byte after a config
//   write may wait for their block (counter 0 is prefetched after reset, the
//   following counter after a config write).
// reset: synchronous; clears counters, queue, prefetch state, output valid and the
//   key and nonce registers.
// stall: out_stall holds the output register; the 4-entry queue keeps accepting
//   until full, then in_stall rises.
`timescale 1ns / 1ps

module chacha20_stream_xor #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [7:0]                            data_byte,
  input  logic                                  message_start,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [7:0]                            out_byte,
  input  logic                                  cfg_we,
  input  ccsx_pkg::cfg_idx_t                    cfg_index,
  input  logic [ccsx_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import ccsx_pkg::*;

  // key and nonce registers
  logic [63:0] key_part_0;
  logic [63:0] key_part_1;
  logic [63:0] key_part_2;
  logic [63:0] key_part_3;
  logic [63:0] nonce_low;
  logic [31:0] nonce_high;

  key_t       key;
  nonce_t     nonce;

  // front to queue
  logic       full;
  logic       push;
  item_t      wr_item;

  // queue to back
  logic       head_valid;
  item_t      head;
  logic       pop;

  // back to block generator
  core_req_t  req;
  core_stat_t stat;
  block_t     core_words;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_part_0 <= '0;
      key_part_1 <= '0;
      key_part_2 <= '0;
      key_part_3 <= '0;
      nonce_low  <= '0;
      nonce_high <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        CFG_KEY_PART_0: key_part_0 <= cfg_data;
        CFG_KEY_PART_1: key_part_1 <= cfg_data;
        CFG_KEY_PART_2: key_part_2 <= cfg_data;
        CFG_KEY_PART_3: key_part_3 <= cfg_data;
        CFG_NONCE_LOW:  nonce_low  <= cfg_data;
        CFG_NONCE_HIGH: nonce_high <= cfg_data[31:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // state words 4..11 and 13..15, little-endian within each 64-bit register
  assign key   = {key_part_3, key_part_2, key_part_1, key_part_0};
  assign nonce = {nonce_high, nonce_low};

  ccsx_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .data_byte     (data_byte),
    .message_start (message_start),
    .full          (full),
    .in_stall      (in_stall),
    .push          (push),
    .item          (wr_item)
  );

  ccsx_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wr_item    (wr_item),
    .full       (full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // any config write aborts the block in flight and drops the prefetch
  ccsx_core #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .key   (key),
    .nonce (nonce),
    .req   (req),
    .kill  (cfg_we),
    .stat  (stat),
    .words (core_words)
  );

  ccsx_back u_back (
    .clk        (clk),
    .rst        (rst),
    .flush      (cfg_we),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .stat       (stat),
    .core_words (core_words),
    .req        (req),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte)
  );

endmodule

// ===== hw/rtl/ccsx_checker.sv =====
// port-level checker for the chacha20 byte combiner and its bind
`timescale 1ns / 1ps

module ccsx_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       cfg_we
);
  import ccsx_pkg::*;

  localparam int PEND_W = $clog2(QUEUE_DEPTH + 2);

  logic              in_acc;
  logic              out_acc;
  logic [PEND_W-1:0] pending;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({in_acc, out_acc})
        2'b10:   pending <= pending + PEND_W'(1);
        2'b01:   pending <= pending - PEND_W'(1);
        default: pending <= pending;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte))
    else $error("stalled output transaction changed");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("output valid or input stall after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != '0)
    else $error("output transaction without a pending input");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= PEND_W'(QUEUE_DEPTH + 1))
    else $error("more transactions in flight than queue and output hold");

  // key and nonce change only with nothing in flight
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_we |-> !out_valid && pending == '0)
    else $error("config write with transactions in flight");

endmodule

bind chacha20_stream_xor ccsx_checker u_ccsx_checker (.*);

// ===== verif/testbench.sv =====
// self-checking testbench for chacha20_stream_xor: directed table, then random streams
`timescale 1ns / 1ps

module testbench;
  import ccsx_pkg::*;

  localparam int ROUND_PAIRS = 10;
  localparam int PHASES = 8;
  localparam int PHASE_BYTES = 232;
  localparam int TABLE_ROWS = 18;
  localparam int MAX_REPORTS = 10;

  // indexes the block has no register behind; writes there must be dropped
  localparam cfg_idx_t SPARE_INDEX_A = 3'd6;
  localparam cfg_idx_t SPARE_INDEX_B = 3'd7;

  // idling modes, one per phase in turn
  localparam int MODE_STEADY = 0;
  localparam int MODE_SENDER_IDLE = 1;
  localparam int MODE_RECEIVER_STALL = 2;
  localparam int MODE_BOTH = 3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] data_byte = 8'h00;
  logic message_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_byte;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_KEY_PART_0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  chacha20_stream_xor #(
    .DOUBLE_ROUNDS(ROUND_PAIRS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .message_start(message_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // keystream predictor: own copy of key, nonce, counter and current block
  // ---------------------------------------------------------------------------
  bit [63:0] cipher_key [4] = '{64'd0, 64'd0, 64'd0, 64'd0};
  bit [63:0] nonce_lo = 64'd0;
  bit [31:0] nonce_hi = 32'd0;
  bit [31:0] block_ctr = 32'd0;
  bit [5:0] stream_pos = 6'd0;
  bit [31:0] keystream [16];
  bit [31:0] round_state [16];

  // bytes the block owes us, oldest first
  bit [7:0] pending_bytes [$];

  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic bit [31:0] spin(bit [31:0] v, int n);
    bit [63:0] t;
    t = {v, v} << n;
    return t[63:32];
  endfunction

  function automatic void quarter_mix(int a, int b, int c, int d);
    round_state[a] += round_state[b];
    round_state[d] = spin(round_state[d] ^ round_state[a], 16);
    round_state[c] += round_state[d];
    round_state[b] = spin(round_state[b] ^ round_state[c], 12);
    round_state[a] += round_state[b];
    round_state[d] = spin(round_state[d] ^ round_state[a], 8);
    round_state[c] += round_state[d];
    round_state[b] = spin(round_state[b] ^ round_state[c], 7);
  endfunction

  // one 64-byte block: constants, key, counter, nonce, rounds, feed-forward
  function automatic void refill_keystream();
    bit [31:0] seed [16];
    seed[0] = 32'h61707865;
    seed[1] = 32'h3320646e;
    seed[2] = 32'h79622d32;
    seed[3] = 32'h6b206574;
    for (int i = 0; i < 4; i++) begin
      seed[4 + 2 * i] = cipher_key[i][31:0];
      seed[5 + 2 * i] = cipher_key[i][63:32];
    end
    seed[12] = block_ctr;
    seed[13] = nonce_lo[31:0];
    seed[14] = nonce_lo[63:32];
    seed[15] = nonce_hi;
    round_state = seed;
    for (int r = 0; r < ROUND_PAIRS; r++) begin
      // columns
      quarter_mix(0, 4, 8, 12);
      quarter_mix(1, 5, 9, 13);
      quarter_mix(2, 6, 10, 14);
      quarter_mix(3, 7, 11, 15);
      // diagonals
      quarter_mix(0, 5, 10, 15);
      quarter_mix(1, 6, 11, 12);
      quarter_mix(2, 7, 8, 13);
      quarter_mix(3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) keystream[i] = round_state[i] + seed[i];
  endfunction

  function automatic bit [7:0] next_cipher_byte(bit [7:0] d, bit restart);
    bit [31:0] w;
    bit [7:0] result;
    if (restart) begin
      block_ctr = 32'd0;
      stream_pos = 6'd0;
    end
    if (stream_pos == 6'd0) refill_keystream();
    w = keystream[stream_pos[5:2]];
    result = d ^ w[8 * stream_pos[1:0] +: 8];
    stream_pos = stream_pos + 6'd1;
    // counter wraps at 2^32 by its width
    if (stream_pos == 6'd0) block_ctr = block_ctr + 32'd1;
    return result;
  endfunction

  // ---------------------------------------------------------------------------
  // directed table, run right after reset with key and nonce all zero;
  // the fixed values are the well-known all-zero keystream 76 b8 e0 ad a0 f1 3d
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [7:0] data;
    logic       restart;
    logic       fixed;
    logic [7:0] want;
  } probe_t;

  probe_t probe_rows [TABLE_ROWS] = '{
    {8'h00, 1'b0, 1'b1, 8'h76},  // first byte after reset, no start flag
    {8'h00, 1'b0, 1'b1, 8'hb8},
    {8'h00, 1'b0, 1'b1, 8'he0},
    {8'hff, 1'b0, 1'b1, 8'h52},  // all-ones data
    {8'hff, 1'b0, 1'b1, 8'h5f},
    {8'h80, 1'b0, 1'b1, 8'h71},
    {8'h01, 1'b0, 1'b1, 8'h3c},
    {8'h00, 1'b1, 1'b1, 8'h76},  // restart in the middle of a block
    {8'h7f, 1'b0, 1'b1, 8'hc7},
    {8'h00, 1'b1, 1'b1, 8'h76},  // restart one byte into a message
    {8'h00, 1'b1, 1'b1, 8'h76},  // back-to-back restarts
    {8'ha5, 1'b0, 1'b0, 8'h00},
    {8'h5a, 1'b0, 1'b0, 8'h00},
    {8'hff, 1'b1, 1'b1, 8'h89},
    {8'hfe, 1'b0, 1'b0, 8'h00},
    {8'h00, 1'b0, 1'b0, 8'h00},
    {8'hc3, 1'b0, 1'b0, 8'h00},
    {8'h3c, 1'b1, 1'b1, 8'h4a}
  };

  // ---------------------------------------------------------------------------
  // output side: random stall and in-order checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin : check_output
    bit [7:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_bytes.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected out_byte %02h with nothing outstanding", out_byte);
        mismatches++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_byte !== want) begin
          if (mismatches < MAX_REPORTS)
            $display("out_byte mismatch: expected %02h got %02h", want, out_byte);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  // one transaction; a fixed want overrides the predictor, which still advances
  task automatic send_byte(input bit [7:0] d, input bit restart, input bit fixed,
                           input bit [7:0] fixed_want);
    bit [7:0] want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= d;
    message_start <= restart;
    do @(posedge clk); while (in_stall);
    want = next_cipher_byte(d, restart);
    pending_bytes.insert(pending_bytes.size(), fixed ? fixed_want : want);
  endtask

  // sender holds off until every outstanding byte is back
  task automatic drain_outputs();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_bytes.size() != 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      CFG_KEY_PART_0: cipher_key[0] = value;
      CFG_KEY_PART_1: cipher_key[1] = value;
      CFG_KEY_PART_2: cipher_key[2] = value;
      CFG_KEY_PART_3: cipher_key[3] = value;
      CFG_NONCE_LOW:  nonce_lo = value;
      CFG_NONCE_HIGH: nonce_hi = value[31:0];
      default: ;
    endcase
  endtask

  // key and nonce for a phase: all ones, all zeros, checkerboard, then random
  task automatic load_phase_config(input int ph);
    logic [63:0] v [6];
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    for (int i = 0; i < 6; i++) begin
      case (ph)
        0: v[i] = '1;
        1: v[i] = '0;
        2: v[i] = (i % 2 == 0) ? 64'h5555_5555_5555_5555 : 64'haaaa_aaaa_aaaa_aaaa;
        default: v[i] = {$urandom, $urandom};
      endcase
    end
    // spare index A first so a wrongly decoded write gets overwritten visibly later; B comes last
    write_reg(SPARE_INDEX_A, {$urandom, $urandom});
    write_reg(CFG_KEY_PART_0, v[0]);
    write_reg(CFG_KEY_PART_1, v[1]);
    write_reg(CFG_KEY_PART_2, v[2]);
    write_reg(CFG_KEY_PART_3, v[3]);
    write_reg(CFG_NONCE_LOW, v[4]);
    // upper half of a nonce_high write is junk the block must ignore
    write_reg(CFG_NONCE_HIGH, {$urandom, v[5][31:0]});
    write_reg(SPARE_INDEX_B, {$urandom, $urandom});
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_msg_len();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return $urandom_range(1, 40);
    if (roll < 90) return $urandom_range(41, 200);
    // exact block multiples end right on a boundary
    return 64 * $urandom_range(1, 3);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int sent;
    int drain_at;
    int msg_len;
    bit restart;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed rows, no idling
    for (int i = 0; i < TABLE_ROWS; i++)
      send_byte(probe_rows[i].data, probe_rows[i].restart, probe_rows[i].fixed,
                probe_rows[i].want);
    in_valid <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      load_phase_config(ph);
      case (ph % 4)
        MODE_STEADY: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        MODE_SENDER_IDLE: begin
          send_idle_pct = 54;
          recv_stall_pct = 0;
        end
        MODE_RECEIVER_STALL: begin
          send_idle_pct = 0;
          recv_stall_pct = 54;
        end
        MODE_BOTH: begin
          send_idle_pct = 20;
          recv_stall_pct = 20;
        end
        default: ;
      endcase

      sent = 0;
      drain_at = $urandom_range(20, PHASE_BYTES - 20);
      while (sent < PHASE_BYTES) begin
        msg_len = pick_msg_len();
        for (int j = 0; j < msg_len && sent < PHASE_BYTES; j++) begin
          if (sent == drain_at) drain_outputs();
          // odd phases keep the old message going across the key change,
          // so the block already held must stay in use
          restart = (j == 0 && !(sent == 0 && ph % 2 == 1)) ||
                    ($urandom_range(99) < 2);
          send_byte(8'($urandom_range(255)), restart, 1'b0, 8'h00);
          sent++;
        end
      end
      in_valid <= 1'b0;
    end

    // let the tail come out
    for (int n = 0; n < 20000 && pending_bytes.size() != 0; n++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pending_bytes.size() != 0) begin
      $display("%0d expected bytes never came out", pending_bytes.size());
      mismatches++;
    end

    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #4000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
